@@ hdl/ordered_integer_set_top_defines.svh @@
// Assertion macros used by the port-level checker of the ordered integer set.
`ifndef ORDERED_INTEGER_SET_TOP_DEFINES_SVH
`define ORDERED_INTEGER_SET_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while reset is low.
`define OSI_ASSERT_IMPL(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ordered_integer_set: same-cycle check failed");

// Next-cycle implication, sampled on clk, off while reset is low.
`define OSI_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ordered_integer_set: next-cycle check failed");

// A condition that must never be seen.
`define OSI_ASSERT_NEVER(name, expr) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("ordered_integer_set: forbidden condition seen");

`endif

@@ hdl/osi_pkg.sv @@
// Shared types and constants of the ordered integer set.
`default_nettype none

package osi_pkg;

    localparam int ACTION_W = 3;
    localparam int KEY_W    = 8;

    // Input word: action, then key, padded to whole bytes.
    localparam int S_DATA_W = 16;
    localparam int S_PAD_W  = S_DATA_W - ACTION_W - KEY_W;

    // Output word: found, then result key, padded to whole bytes.
    localparam int M_DATA_W = 16;
    localparam int M_PAD_W  = M_DATA_W - 1 - KEY_W;

    localparam logic [ACTION_W-1:0] ACT_INSERT = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_DELETE = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_MEMBER = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_SUCC   = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_PRED   = 3'd4;

    // Control of the shared bit scan unit.
    typedef struct packed {
        logic up;      // 1: lowest set bit, 0: highest set bit
        logic strict;  // 1: only bits strictly beyond pos, 0: whole vector
    } scan_ctl_t;

endpackage

`default_nettype wire

@@ hdl/ordered_integer_set_top.sv @@
// Top level of the ordered integer set (two-level bitmap, van Emde Boas style).
//
// Channel   Dir  Word                                   Handshake
// s_*       in   action[2:0], key[10:3], zero [15:11]   s_tvalid & s_tready
// m_*       out  found[0], result_key[8:1], zero [15:9] m_tvalid & m_tready
//
// Flow: s_tready is high only while idle. After acceptance the key's cluster row is
// read and scanned (S_ROW), and the result is offered (S_OUT) when the answer lies in
// the key's own cluster or in the min/max registers; a neighbor search that leaves the
// cluster adds a summary scan (S_SUM), then, if it finds an occupied cluster, a read
// and scan of that cluster (S_ROW2). A new word is taken only after the result.
// The registered cluster memory read and the one shared bit scan unit set these steps.
// Reset clears the summary bitmap, which also marks the valid cluster rows, so
// no clearing pass is needed. A stalled m_tready holds the result and the block.
// CLUSTER_SIZE and UNIVERSE / CLUSTER_SIZE must be powers of two.
`default_nettype none

module ordered_integer_set_top #(
    parameter int UNIVERSE     = 256,
    parameter int CLUSTER_SIZE = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [osi_pkg::S_DATA_W-1:0]  s_tdata,   // action[2:0], key[10:3]
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [osi_pkg::M_DATA_W-1:0]  m_tdata    // found[0], result_key[8:1]
);
    import osi_pkg::*;

    localparam int NCLUSTERS = UNIVERSE / CLUSTER_SIZE;
    localparam int CL_W      = $clog2(CLUSTER_SIZE);
    localparam int NC_W      = (NCLUSTERS > 1) ? $clog2(NCLUSTERS) : 1;
    localparam int NCL_P     = 1 << NC_W;
    localparam int SW        = (CLUSTER_SIZE > NCL_P) ? CLUSTER_SIZE : NCL_P;
    localparam int SI_W      = $clog2(SW);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_ROW  = 3'd1;
    localparam logic [2:0] S_SUM  = 3'd2;
    localparam logic [2:0] S_ROW2 = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    localparam logic [1:0] TGT_OUT = 2'd0;
    localparam logic [1:0] TGT_MIN = 2'd1;
    localparam logic [1:0] TGT_MAX = 2'd2;

    // Join a cluster index and a position into a key.
    function automatic logic [KEY_W-1:0] make_key(input logic [NC_W-1:0] c,
                                                  input logic [CL_W-1:0] p);
        make_key = KEY_W'((32'(c) << CL_W) | 32'(p));
    endfunction

    logic [2:0]              state_reg, state_next;
    logic [ACTION_W-1:0]     action_reg, action_next;
    logic [KEY_W-1:0]        key_reg, key_next;
    logic [NC_W-1:0]         h_reg, h_next;
    logic [CL_W-1:0]         l_reg, l_next;
    logic [NC_W-1:0]         c_reg, c_next;
    logic                    inside_reg, inside_next;
    logic                    dir_reg, dir_next;
    logic [1:0]              tgt_reg, tgt_next;
    logic                    found_reg, found_next;
    logic [KEY_W-1:0]        rkey_reg, rkey_next;
    logic [KEY_W-1:0]        min_reg, min_next;
    logic [KEY_W-1:0]        max_reg, max_next;
    logic                    empty_reg, empty_next;
    logic [NCL_P-1:0]        summary_reg, summary_next;

    // Cluster bitmaps; a row is only meaningful while its summary bit is set.
    logic [CLUSTER_SIZE-1:0] mem [NCL_P];
    logic [CLUSTER_SIZE-1:0] rd_data_reg;
    logic [NC_W-1:0]         rd_addr;
    logic                    mem_we;
    logic [CLUSTER_SIZE-1:0] mem_wdata;

    logic [ACTION_W-1:0]     action_in;
    logic [KEY_W-1:0]        key_in;
    logic [NC_W-1:0]         h_in;
    logic [NC_W-1:0]         h_sel;
    logic [CLUSTER_SIZE-1:0] row;
    logic [CLUSTER_SIZE-1:0] bit_mask;
    logic [CLUSTER_SIZE-1:0] row_cleared;
    logic                    row_up;

    logic [SW-1:0]           scan_vec;
    logic [SI_W-1:0]         scan_pos;
    scan_ctl_t               scan_ctl;
    logic                    scan_hit;
    logic [SI_W-1:0]         scan_idx;
    logic [KEY_W-1:0]        scan_key;

    assign action_in = s_tdata[ACTION_W-1:0];
    assign key_in    = s_tdata[ACTION_W +: KEY_W];
    assign h_in      = NC_W'(32'(key_in) >> CL_W);

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = (state_reg == S_OUT);
    assign m_tdata  = {{M_PAD_W{1'b0}}, rkey_reg, found_reg};

    // Rows whose summary bit is clear read as empty.
    assign h_sel       = (state_reg == S_ROW2) ? c_reg : h_reg;
    assign row         = summary_reg[h_sel] ? rd_data_reg : '0;
    assign bit_mask    = {{(CLUSTER_SIZE-1){1'b0}}, 1'b1} << l_reg;
    assign row_cleared = row & ~bit_mask;

    // Scan upward for successor and for a deleted minimum, downward otherwise.
    assign row_up = (action_reg == ACT_SUCC) ||
                    ((action_reg == ACT_DELETE) && (key_reg == min_reg));

    always_comb
    begin
        scan_vec = SW'(row);
        scan_pos = SI_W'(l_reg);
        scan_ctl = '{up: row_up, strict: 1'b1};
        case (state_reg)
            S_SUM:
            begin
                scan_vec = SW'(summary_reg);
                scan_pos = SI_W'(h_reg);
                scan_ctl = '{up: dir_reg, strict: 1'b1};
            end
            S_ROW2:
            begin
                scan_ctl = '{up: dir_reg, strict: 1'b0};
            end
            default:
            begin
            end
        endcase
    end

    osi_scan #(
        .W (SW)
    ) u_scan (
        .vec (scan_vec),
        .pos (scan_pos),
        .ctl (scan_ctl),
        .hit (scan_hit),
        .idx (scan_idx)
    );

    assign scan_key = make_key((state_reg == S_ROW2) ? c_reg : h_reg, CL_W'(scan_idx));

    always_comb
    begin
        state_next   = state_reg;
        action_next  = action_reg;
        key_next     = key_reg;
        h_next       = h_reg;
        l_next       = l_reg;
        c_next       = c_reg;
        inside_next  = inside_reg;
        dir_next     = dir_reg;
        tgt_next     = tgt_reg;
        found_next   = found_reg;
        rkey_next    = rkey_reg;
        min_next     = min_reg;
        max_next     = max_reg;
        empty_next   = empty_reg;
        summary_next = summary_reg;
        rd_addr      = h_in;
        mem_we       = 1'b0;
        mem_wdata    = row;

        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    action_next = action_in;
                    key_next    = key_in;
                    h_next      = h_in;
                    l_next      = CL_W'(key_in);
                    inside_next = (32'(key_in) < 32'(UNIVERSE));
                    state_next  = S_ROW;
                end
            end

            S_ROW:
            begin
                found_next = 1'b0;
                rkey_next  = key_reg;
                dir_next   = row_up;
                tgt_next   = TGT_OUT;
                state_next = S_OUT;
                case (action_reg)
                    ACT_INSERT:
                    begin
                        if (inside_reg && !row[l_reg])
                        begin
                            mem_we              = 1'b1;
                            mem_wdata           = row | bit_mask;
                            summary_next[h_reg] = 1'b1;
                            found_next          = 1'b1;
                            if (empty_reg)
                            begin
                                min_next   = key_reg;
                                max_next   = key_reg;
                                empty_next = 1'b0;
                            end
                            else
                            begin
                                if (key_reg < min_reg)
                                    min_next = key_reg;
                                if (key_reg > max_reg)
                                    max_next = key_reg;
                            end
                        end
                    end

                    ACT_DELETE:
                    begin
                        if (inside_reg && row[l_reg])
                        begin
                            mem_we              = 1'b1;
                            mem_wdata           = row_cleared;
                            summary_next[h_reg] = |row_cleared;
                            found_next          = 1'b1;
                            if (min_reg == max_reg)
                            begin
                                empty_next = 1'b1;
                                min_next   = '0;
                                max_next   = '0;
                            end
                            else if ((key_reg == min_reg) || (key_reg == max_reg))
                            begin
                                // replace the removed bound with its neighbor
                                tgt_next = (key_reg == min_reg) ? TGT_MIN : TGT_MAX;
                                if (!scan_hit)
                                    state_next = S_SUM;
                                else if (key_reg == min_reg)
                                    min_next = scan_key;
                                else
                                    max_next = scan_key;
                            end
                        end
                    end

                    ACT_MEMBER:
                    begin
                        found_next = inside_reg && row[l_reg];
                    end

                    ACT_SUCC:
                    begin
                        rkey_next = '0;
                        if (!empty_reg && inside_reg)
                        begin
                            if (key_reg < min_reg)
                            begin
                                found_next = 1'b1;
                                rkey_next  = min_reg;
                            end
                            else if (key_reg < max_reg)
                            begin
                                if (scan_hit)
                                begin
                                    found_next = 1'b1;
                                    rkey_next  = scan_key;
                                end
                                else
                                    state_next = S_SUM;
                            end
                        end
                    end

                    ACT_PRED:
                    begin
                        rkey_next = '0;
                        if (!empty_reg)
                        begin
                            if (!inside_reg || (key_reg > max_reg))
                            begin
                                found_next = 1'b1;
                                rkey_next  = max_reg;
                            end
                            else if (key_reg > min_reg)
                            begin
                                if (scan_hit)
                                begin
                                    found_next = 1'b1;
                                    rkey_next  = scan_key;
                                end
                                else
                                    state_next = S_SUM;
                            end
                        end
                    end

                    default:
                    begin
                    end
                endcase
            end

            S_SUM:
            begin
                if (scan_hit)
                begin
                    // fetch the nearest occupied cluster
                    c_next     = NC_W'(scan_idx);
                    rd_addr    = NC_W'(scan_idx);
                    state_next = S_ROW2;
                end
                else
                begin
                    case (tgt_reg)
                        TGT_MIN: min_next = '0;
                        TGT_MAX: max_next = '0;
                        default:
                        begin
                            found_next = 1'b0;
                            rkey_next  = '0;
                        end
                    endcase
                    state_next = S_OUT;
                end
            end

            S_ROW2:
            begin
                case (tgt_reg)
                    TGT_MIN: min_next = scan_hit ? scan_key : '0;
                    TGT_MAX: max_next = scan_hit ? scan_key : '0;
                    default:
                    begin
                        found_next = scan_hit;
                        rkey_next  = scan_hit ? scan_key : '0;
                    end
                endcase
                state_next = S_OUT;
            end

            S_OUT:
            begin
                if (m_tready)
                    state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            min_reg     <= '0;
            max_reg     <= '0;
            empty_reg   <= 1'b1;
            summary_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            min_reg     <= min_next;
            max_reg     <= max_next;
            empty_reg   <= empty_next;
            summary_reg <= summary_next;
        end
    end

    always_ff @(posedge clk)
    begin
        action_reg <= action_next;
        key_reg    <= key_next;
        h_reg      <= h_next;
        l_reg      <= l_next;
        c_reg      <= c_next;
        inside_reg <= inside_next;
        dir_reg    <= dir_next;
        tgt_reg    <= tgt_next;
        found_reg  <= found_next;
        rkey_reg   <= rkey_next;
    end

    // Cluster memory: one write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[h_reg] <= mem_wdata;
        rd_data_reg <= mem[rd_addr];
    end

endmodule

`default_nettype wire

@@ hdl/osi_scan.sv @@
// Shared bit scan unit: first or last set bit, optionally beyond a position.
`default_nettype none

module osi_scan #(
    parameter int W = 16
) (
    input  logic [W-1:0]         vec,
    input  logic [$clog2(W)-1:0] pos,
    input  osi_pkg::scan_ctl_t   ctl,
    output logic                 hit,
    output logic [$clog2(W)-1:0] idx
);
    import osi_pkg::*;

    localparam int IW = $clog2(W);

    logic [W-1:0] masked;

    always_comb
    begin
        for (int i = 0; i < W; i++)
        begin
            if (!ctl.strict)
                masked[i] = vec[i];
            else if (ctl.up)
                masked[i] = vec[i] && (IW'(i) > pos);
            else
                masked[i] = vec[i] && (IW'(i) < pos);
        end
    end

    always_comb
    begin
        hit = 1'b0;
        idx = '0;
        if (ctl.up)
        begin
            // descend so the lowest set bit wins
            for (int i = W - 1; i >= 0; i--)
            begin
                if (masked[i])
                begin
                    hit = 1'b1;
                    idx = IW'(i);
                end
            end
        end
        else
        begin
            for (int i = 0; i < W; i++)
            begin
                if (masked[i])
                begin
                    hit = 1'b1;
                    idx = IW'(i);
                end
            end
        end
    end

endmodule

`default_nettype wire

@@ hdl/osi_chk.sv @@
// Port-level checker of the ordered integer set, bound to the top level.
`default_nettype none
`include "ordered_integer_set_top_defines.svh"

module osi_chk (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [osi_pkg::M_DATA_W-1:0]  m_tdata
);
    import osi_pkg::*;

    logic s_fire;
    logic m_fire;

    assign s_fire = s_tvalid && s_tready;
    assign m_fire = m_tvalid && m_tready;

    // One word in flight: busy right after acceptance.
    `OSI_ASSERT_NEXT(a_busy_after_accept, s_fire, !s_tready)

    // Never ready for input while a result is on offer.
    `OSI_ASSERT_NEVER(a_ready_xor_result, s_tready && m_tvalid)

    // Back to idle as soon as the result is taken.
    `OSI_ASSERT_NEXT(a_idle_after_result, m_fire, s_tready && !m_tvalid)

    // A stalled result holds.
    `OSI_ASSERT_NEXT(a_result_holds, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

endmodule

bind ordered_integer_set_top osi_chk u_osi_chk (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

@@ sim/ordered_integer_set_top_test.sv @@
// Self-checking testbench of the ordered integer set: directed, then random actions against a bitmap model.
`timescale 1ns / 1ps

module ordered_integer_set_top_test;

    import osi_pkg::*;

    localparam int UNIVERSE     = 256;
    localparam int CLUSTER      = 16;
    localparam int ROWS         = UNIVERSE / CLUSTER;
    localparam int ACT_CODES    = 1 << ACTION_W;
    localparam int RANDOM_WORDS = 1750;
    localparam int PHASE_WORDS  = 250;
    localparam int HOLD_CYCLES  = 250;
    localparam int DRAIN_CYCLES = 20;
    localparam int CYCLE_LIMIT  = 400000;

    // The universe is a square, so a cluster row and the summary share one width.
    typedef logic [CLUSTER-1:0] bits_t;

    typedef struct {
        logic              found;
        logic [KEY_W-1:0]  key;
    } answer_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [S_DATA_W-1:0]    s_tdata = '0;   // action[2:0], key[10:3]
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [M_DATA_W-1:0]    m_tdata;        // found[0], result_key[8:1]

    // Model of the stored set.
    bits_t                  member_rows [ROWS];
    bits_t                  occupied_rows;
    logic [KEY_W-1:0]       low_key;
    logic [KEY_W-1:0]       high_key;
    logic                   set_is_empty;

    logic [S_DATA_W-1:0]    pending_words [$];
    answer_t                expected_answers [$];

    // Keys the stimulus believes present, used to aim deletes and lookups.
    logic [UNIVERSE-1:0]    planned_set = '0;
    int                     planned_keys [$];

    int                     total_words = 0;
    int                     results_checked = 0;
    int                     mismatches = 0;
    int                     cycle_count = 0;
    int                     send_gap = 0;
    int                     recv_wait = 0;
    bit                     send_quiet = 1'b0;
    bit                     recv_quiet = 1'b0;
    logic                   hold_off = 1'b0;
    logic                   word_accepted = 1'b0;
    logic                   result_accepted = 1'b0;

    ordered_integer_set_top #(
        .UNIVERSE     (UNIVERSE),
        .CLUSTER_SIZE (CLUSTER)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 clk = ~clk;

    // Lowest set bit at or above start, or -1.
    function automatic int lowest_from(bits_t v, int start);
        int i;
        int hit;
        hit = -1;
        for (i = CLUSTER - 1; i >= 0; i--)
            if (i >= start && v[i])
                hit = i;
        return hit;
    endfunction

    // Highest set bit at or below start, or -1.
    function automatic int highest_upto(bits_t v, int start);
        int i;
        int hit;
        hit = -1;
        for (i = 0; i < CLUSTER; i++)
            if (i <= start && v[i])
                hit = i;
        return hit;
    endfunction

    // Smallest member strictly above k: own row first, then the next occupied row.
    function automatic int member_above(int k);
        int h;
        int p;
        int c;
        h = k / CLUSTER;
        p = lowest_from(member_rows[h], k % CLUSTER + 1);
        if (p >= 0)
            return h * CLUSTER + p;
        c = lowest_from(occupied_rows, h + 1);
        if (c < 0)
            return -1;
        p = lowest_from(member_rows[c], 0);
        return (p < 0) ? -1 : c * CLUSTER + p;
    endfunction

    // Largest member strictly below k.
    function automatic int member_below(int k);
        int h;
        int p;
        int c;
        h = k / CLUSTER;
        p = highest_upto(member_rows[h], k % CLUSTER - 1);
        if (p >= 0)
            return h * CLUSTER + p;
        c = highest_upto(occupied_rows, h - 1);
        if (c < 0)
            return -1;
        p = highest_upto(member_rows[c], CLUSTER - 1);
        return (p < 0) ? -1 : c * CLUSTER + p;
    endfunction

    // Apply one action to the model set and return the answer the block owes.
    function automatic void apply_set_action(input logic [ACTION_W-1:0] act,
                                             input logic [KEY_W-1:0] k,
                                             output answer_t ans);
        int h;
        int l;
        int r;
        h = int'(k) / CLUSTER;
        l = int'(k) % CLUSTER;
        ans.found = 1'b0;
        ans.key   = k;
        case (act)
            ACT_INSERT:
                if (!member_rows[h][l])
                begin
                    member_rows[h][l] = 1'b1;
                    occupied_rows[h]  = 1'b1;
                    if (set_is_empty)
                    begin
                        low_key      = k;
                        high_key     = k;
                        set_is_empty = 1'b0;
                    end
                    else
                    begin
                        if (k < low_key)
                            low_key = k;
                        if (k > high_key)
                            high_key = k;
                    end
                    ans.found = 1'b1;
                end
            ACT_DELETE:
                if (member_rows[h][l])
                begin
                    member_rows[h][l] = 1'b0;
                    if (member_rows[h] == '0)
                        occupied_rows[h] = 1'b0;
                    if (low_key == high_key)
                    begin
                        set_is_empty = 1'b1;
                        low_key      = '0;
                        high_key     = '0;
                    end
                    else
                    begin
                        // Compare against the old bounds; the bitmap is already updated.
                        if (k == low_key)
                        begin
                            r = member_above(int'(k));
                            low_key = (r < 0) ? '0 : r[KEY_W-1:0];
                        end
                        if (k == high_key)
                        begin
                            r = member_below(int'(k));
                            high_key = (r < 0) ? '0 : r[KEY_W-1:0];
                        end
                    end
                    ans.found = 1'b1;
                end
            ACT_MEMBER:
                ans.found = member_rows[h][l];
            ACT_SUCC:
            begin
                ans.key = '0;
                if (!set_is_empty)
                begin
                    if (k < low_key)
                    begin
                        ans.found = 1'b1;
                        ans.key   = low_key;
                    end
                    else if (k < high_key)
                    begin
                        r = member_above(int'(k));
                        if (r >= 0)
                        begin
                            ans.found = 1'b1;
                            ans.key   = r[KEY_W-1:0];
                        end
                    end
                end
            end
            ACT_PRED:
            begin
                ans.key = '0;
                if (!set_is_empty)
                begin
                    if (k > high_key)
                    begin
                        ans.found = 1'b1;
                        ans.key   = high_key;
                    end
                    else if (k > low_key)
                    begin
                        r = member_below(int'(k));
                        if (r >= 0)
                        begin
                            ans.found = 1'b1;
                            ans.key   = r[KEY_W-1:0];
                        end
                    end
                end
            end
            default: ;  // unused codes leave the set alone and echo the key
        endcase
    endfunction

    // Pack one word for the driver and track what the set will hold afterwards.
    task automatic queue_word(input logic [ACTION_W-1:0] act, input logic [KEY_W-1:0] k);
        int i;
        pending_words.push_back({{S_PAD_W{1'b0}}, k, act});
        total_words++;
        if (act == ACT_INSERT && !planned_set[k])
        begin
            planned_set[k] = 1'b1;
            planned_keys.push_back(int'(k));
        end
        else if (act == ACT_DELETE && planned_set[k])
        begin
            planned_set[k] = 1'b0;
            for (i = 0; i < planned_keys.size(); i++)
                if (planned_keys[i] == int'(k))
                begin
                    planned_keys.delete(i);
                    break;
                end
        end
    endtask

    // Half the keys anywhere, most others in two busy clusters, the rest at edges.
    function automatic logic [KEY_W-1:0] pick_key(int hot_a, int hot_b);
        int r;
        int c;
        r = int'($urandom_range(0, 9));
        c = int'($urandom_range(0, ROWS - 1));
        if (r == 0)
        begin
            case ($urandom_range(0, 3))
                0:       return '0;
                1:       return KEY_W'(UNIVERSE - 1);
                2:       return KEY_W'(c * CLUSTER);
                default: return KEY_W'(c * CLUSTER + CLUSTER - 1);
            endcase
        end
        if (r <= 2)
            return KEY_W'(hot_a * CLUSTER + int'($urandom_range(0, CLUSTER - 1)));
        if (r <= 4)
            return KEY_W'(hot_b * CLUSTER + int'($urandom_range(0, CLUSTER - 1)));
        return KEY_W'($urandom_range(0, UNIVERSE - 1));
    endfunction

    function automatic logic [KEY_W-1:0] present_or_any(int hot_a, int hot_b);
        if (planned_keys.size() > 0 && $urandom_range(0, 9) < 7)
            return KEY_W'(planned_keys[$urandom_range(0, planned_keys.size() - 1)]);
        return pick_key(hot_a, hot_b);
    endfunction

    task automatic queue_random_words();
        int i;
        int r;
        int ins_pct;
        int del_pct;
        int hot_a;
        int hot_b;
        // Insert and delete shares per phase: grow, churn, shrink, grow hard, shrink, churn, drain.
        int ins_mix [7] = '{60, 30, 10, 70, 20, 40, 5};
        int del_mix [7] = '{10, 30, 60, 5, 40, 40, 80};
        for (i = 0; i < RANDOM_WORDS; i++)
        begin
            if (i % PHASE_WORDS == 0)
            begin
                ins_pct = ins_mix[(i / PHASE_WORDS) % 7];
                del_pct = del_mix[(i / PHASE_WORDS) % 7];
                hot_a   = int'($urandom_range(0, ROWS - 1));
                hot_b   = int'($urandom_range(0, ROWS - 1));
            end
            r = int'($urandom_range(0, 99));
            if (r < 2)
                queue_word(ACTION_W'($urandom_range(ACT_PRED + 1, ACT_CODES - 1)),
                           KEY_W'($urandom_range(0, UNIVERSE - 1)));
            else if (r < 2 + ins_pct)
                queue_word(ACT_INSERT, pick_key(hot_a, hot_b));
            else if (r < 2 + ins_pct + del_pct)
                queue_word(ACT_DELETE, present_or_any(hot_a, hot_b));
            else if (r < 2 + ins_pct + del_pct + (98 - ins_pct - del_pct) / 3)
                queue_word(ACT_MEMBER, present_or_any(hot_a, hot_b));
            else if (r % 2 == 0)
                queue_word(ACT_SUCC, pick_key(hot_a, hot_b));
            else
                queue_word(ACT_PRED, pick_key(hot_a, hot_b));
        end
    endtask

    // Sender: hold a word until taken, then wait a drawn gap before the next.
    always @(negedge clk)
    begin
        if (rst_n && (!s_tvalid || word_accepted))
        begin
            if (word_accepted)
            begin
                if ($urandom_range(0, 31) == 0)
                    send_quiet = !send_quiet;
                send_gap = send_quiet ? 0 : int'($urandom_range(0, 15));
            end
            if (send_gap > 0)
            begin
                send_gap--;
                s_tvalid <= 1'b0;
            end
            else if (pending_words.size() > 0)
            begin
                s_tdata  <= pending_words.pop_front();
                s_tvalid <= 1'b1;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // Receiver: after each result, stall a drawn number of cycles.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (result_accepted)
            begin
                if ($urandom_range(0, 31) == 0)
                    recv_quiet = !recv_quiet;
                recv_wait = recv_quiet ? 0 : int'($urandom_range(0, 15));
            end
            if (hold_off)
                m_tready <= 1'b0;
            else if (recv_wait > 0)
            begin
                recv_wait--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // Long output stalls while the sender keeps offering, so the block backs up.
    initial
    begin
        wait (results_checked >= 400);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
        wait (results_checked >= 1300);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    // Predict on every accepted input word, check every accepted output word.
    always @(posedge clk)
    begin : monitor
        answer_t ans;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                apply_set_action(s_tdata[ACTION_W-1:0], s_tdata[ACTION_W +: KEY_W], ans);
                expected_answers.push_back(ans);
            end
            if (m_tvalid && m_tready)
            begin
                if (expected_answers.size() == 0)
                begin
                    $display("%0t: unexpected result, found %0d key %0d", $time,
                             m_tdata[0], m_tdata[1 +: KEY_W]);
                    mismatches++;
                end
                else
                begin
                    ans = expected_answers.pop_front();
                    if (m_tdata[0] !== ans.found)
                    begin
                        $display("%0t: found mismatch, expected %0d actual %0d", $time,
                                 ans.found, m_tdata[0]);
                        mismatches++;
                    end
                    if (m_tdata[1 +: KEY_W] !== ans.key)
                    begin
                        $display("%0t: result_key mismatch, expected %0d actual %0d", $time,
                                 ans.key, m_tdata[1 +: KEY_W]);
                        mismatches++;
                    end
                end
                results_checked++;
            end
        end
        word_accepted   <= rst_n && s_tvalid && s_tready;
        result_accepted <= rst_n && m_tvalid && m_tready;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout, %0d words still expected", $time, expected_answers.size());
            $display("ordered_integer_set_top test failed");
            $finish;
        end
    end

    initial
    begin
        int i;
        for (i = 0; i < ROWS; i++)
            member_rows[i] = '0;
        occupied_rows = '0;
        low_key       = '0;
        high_key      = '0;
        set_is_empty  = 1'b1;

        // Empty set: no neighbors, nothing to delete.
        queue_word(ACT_SUCC, 8'd0);
        queue_word(ACT_PRED, 8'd255);
        queue_word(ACT_DELETE, 8'd9);
        // Both ends of the universe, then a duplicate insert.
        queue_word(ACT_INSERT, 8'd0);
        queue_word(ACT_INSERT, 8'd255);
        queue_word(ACT_INSERT, 8'd0);
        queue_word(ACT_MEMBER, 8'd0);
        queue_word(ACT_MEMBER, 8'd255);
        queue_word(ACT_MEMBER, 8'd128);
        queue_word(ACT_SUCC, 8'd0);
        queue_word(ACT_PRED, 8'd255);
        queue_word(ACT_SUCC, 8'd255);
        queue_word(ACT_PRED, 8'd0);
        // Neighbor searches inside a cluster and across clusters.
        queue_word(ACT_INSERT, 8'd17);
        queue_word(ACT_INSERT, 8'd18);
        queue_word(ACT_INSERT, 8'd200);
        queue_word(ACT_SUCC, 8'd17);
        queue_word(ACT_SUCC, 8'd18);
        queue_word(ACT_PRED, 8'd200);
        // Delete both bounds and an absent key.
        queue_word(ACT_DELETE, 8'd0);
        queue_word(ACT_DELETE, 8'd255);
        queue_word(ACT_DELETE, 8'd5);
        // Unused action codes.
        queue_word(ACTION_W'(ACT_PRED + 1), 8'd170);
        queue_word(ACTION_W'(ACT_CODES - 1), 8'd85);
        // Drain to empty through the maximum.
        queue_word(ACT_DELETE, 8'd200);
        queue_word(ACT_DELETE, 8'd17);
        queue_word(ACT_DELETE, 8'd18);
        queue_word(ACT_PRED, 8'd100);

        queue_random_words();

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        wait (results_checked >= total_words);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && expected_answers.size() == 0)
            $display("ordered_integer_set_top test passed");
        else
            $display("ordered_integer_set_top test failed");
        $finish;
    end

endmodule
